// ===== rtl/ate_pkg.sv =====
// Shared types, codes and colour helpers of the ANSI terminal escape engine.
// Used by ate_sgr, ate_checker and the top level; depends on nothing.
package ate_pkg;

    localparam int TEXT_COLS_DEF   = 40;
    localparam int TEXT_ROWS_DEF   = 29;
    localparam int PARAM_SLOTS_DEF = 5;

    localparam logic [13:0] PARAM_MAX = 14'd9999;

    localparam logic [15:0] FG_RESET = 16'd32767;
    localparam logic [15:0] BG_RESET = 16'd17928;

    localparam logic [1:0] CFG_FG   = 2'd0;
    localparam logic [1:0] CFG_BG   = 2'd1;
    localparam logic [1:0] CFG_WRAP = 2'd2;

    localparam logic [7:0] CH_BS     = 8'h08;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_FF     = 8'h0C;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_ESC    = 8'h1B;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_NINE   = 8'h39;
    localparam logic [7:0] CH_SEMI   = 8'h3B;
    localparam logic [7:0] CH_QUEST  = 8'h3F;
    localparam logic [7:0] CH_FIN_LO = 8'h40;
    localparam logic [7:0] CH_FIN_HI = 8'h7D;
    localparam logic [7:0] CH_LBRACK = 8'h5B;
    localparam logic [7:0] CH_A      = 8'h41;
    localparam logic [7:0] CH_B      = 8'h42;
    localparam logic [7:0] CH_C      = 8'h43;
    localparam logic [7:0] CH_D      = 8'h44;
    localparam logic [7:0] CH_H      = 8'h48;
    localparam logic [7:0] CH_J      = 8'h4A;
    localparam logic [7:0] CH_K      = 8'h4B;
    localparam logic [7:0] CH_S      = 8'h53;
    localparam logic [7:0] CH_U      = 8'h55;
    localparam logic [7:0] CH_LH     = 8'h68;
    localparam logic [7:0] CH_LL     = 8'h6C;
    localparam logic [7:0] CH_LM     = 8'h6D;
    localparam logic [7:0] CH_LS     = 8'h73;
    localparam logic [7:0] CH_LU     = 8'h75;

    localparam logic [2:0] CLR_SCR_FROM  = 3'd0;
    localparam logic [2:0] CLR_SCR_TO    = 3'd1;
    localparam logic [2:0] CLR_SCR       = 3'd2;
    localparam logic [2:0] CLR_LINE_FROM = 3'd3;

    typedef enum logic [1:0] {
        PH_READY = 2'd0,
        PH_ESC   = 2'd1,
        PH_CSI   = 2'd2
    } phase_t;

    typedef enum logic [2:0] {
        OP_DRAW   = 3'd0,
        OP_SCROLL = 3'd1,
        OP_CLEAR  = 3'd2,
        OP_FONT   = 3'd3,
        OP_CURSOR = 3'd4
    } op_t;

    typedef struct packed {
        op_t         op;
        logic [6:0]  col;
        logic [5:0]  row;
        logic [7:0]  glyph;
        logic [2:0]  font_row;
        logic [7:0]  font_data;
        logic [15:0] fg;
        logic [15:0] bg;
        logic [5:0]  cnt;
        logic [2:0]  mode;
        logic        con;
        logic        last;
    } ate_res_t;

    typedef struct packed {
        logic        set_ink;
        logic        set_paper;
        logic [15:0] colour;
        logic        rev_on;
        logic        rev_off;
        logic        ink_reset;
    } ate_sgr_t;

    function automatic logic [15:0] pal(input logic [3:0] i);
        logic [15:0] v;
        case (i)
            4'd0:    v = 16'd0;
            4'd1:    v = 16'd21;
            4'd2:    v = 16'd672;
            4'd3:    v = 16'd341;
            4'd4:    v = 16'd21504;
            4'd5:    v = 16'd21525;
            4'd6:    v = 16'd22176;
            4'd7:    v = 16'd22197;
            4'd8:    v = 16'd10570;
            4'd9:    v = 16'd10591;
            4'd10:   v = 16'd11242;
            4'd11:   v = 16'd11263;
            4'd12:   v = 16'd31744;
            4'd13:   v = 16'd32095;
            4'd14:   v = 16'd32746;
            default: v = 16'd32767;
        endcase
        return v;
    endfunction

    function automatic logic [4:0] lvl(input logic [2:0] k);
        logic [4:0] v;
        case (k)
            3'd0:    v = 5'd0;
            3'd1:    v = 5'd5;
            3'd2:    v = 5'd10;
            3'd3:    v = 5'd15;
            3'd4:    v = 5'd21;
            default: v = 5'd26;
        endcase
        return v;
    endfunction

    function automatic logic [4:0] gray(input logic [4:0] k);
        logic [4:0] v;
        case (k)
            5'd0:    v = 5'd0;
            5'd1:    v = 5'd1;
            5'd2:    v = 5'd2;
            5'd3:    v = 5'd3;
            5'd4:    v = 5'd5;
            5'd5:    v = 5'd6;
            5'd6:    v = 5'd7;
            5'd7:    v = 5'd9;
            5'd8:    v = 5'd10;
            5'd9:    v = 5'd11;
            5'd10:   v = 5'd13;
            5'd11:   v = 5'd14;
            5'd12:   v = 5'd15;
            5'd13:   v = 5'd17;
            5'd14:   v = 5'd18;
            5'd15:   v = 5'd19;
            5'd16:   v = 5'd21;
            5'd17:   v = 5'd22;
            5'd18:   v = 5'd23;
            5'd19:   v = 5'd25;
            5'd20:   v = 5'd26;
            5'd21:   v = 5'd27;
            5'd22:   v = 5'd29;
            default: v = 5'd30;
        endcase
        return v;
    endfunction

    function automatic logic [4:0] sat5(input logic [13:0] v);
        return (v > 14'd255) ? 5'd31 : v[7:3];
    endfunction

    function automatic logic [15:0] c256(input logic [7:0] n);
        logic [7:0]  c;
        logic [7:0]  q6;
        logic [2:0]  q36;
        logic [2:0]  r;
        logic [2:0]  g;
        logic [2:0]  b;
        logic [4:0]  k;
        logic [15:0] v;
        c   = n - 8'd16;
        q6  = 8'((18'(c) * 18'd171) >> 10);
        r   = 3'((18'(c) * 18'd456) >> 14);
        q36 = 3'((14'(q6) * 14'd43) >> 8);
        g   = 3'(q6 - 8'(q36) * 8'd6);
        b   = 3'(c - q6 * 8'd6);
        k   = 5'(n - 8'd232);
        if (n < 8'd16) begin
            v = pal(n[3:0]);
        end
        else if (n < 8'd232) begin
            v = {1'b0, lvl(b), lvl(g), lvl(r)};
        end
        else begin
            v = {1'b0, gray(k), gray(k), gray(k)};
        end
        return v;
    endfunction

endpackage

// ===== rtl/ate_sgr.sv =====
// Select-graphic-rendition decode: turns the first five CSI parameters into
// colour and reverse-video updates. Depends on ate_pkg.
module ate_sgr (
    input  logic [13:0]       p0,
    input  logic [13:0]       p1,
    input  logic [13:0]       p2,
    input  logic [13:0]       p3,
    input  logic [13:0]       p4,
    output ate_pkg::ate_sgr_t sgr
);
    import ate_pkg::*;

    always_comb
    begin
        sgr = '0;
        if (p0 == 14'd0) begin
            sgr.rev_off   = 1'b1;
            sgr.ink_reset = 1'b1;
        end
        else if (p0 == 14'd7) begin
            sgr.rev_on = 1'b1;
        end
        else if (p0 inside {[14'd30:14'd37]}) begin
            sgr.set_ink = 1'b1;
            sgr.colour  = pal(4'(p0 - 14'd30));
        end
        else if (p0 inside {[14'd40:14'd47]}) begin
            sgr.set_paper = 1'b1;
            sgr.colour    = pal(4'(p0 - 14'd40));
        end
        else if (p0 inside {[14'd90:14'd97]}) begin
            sgr.set_ink = 1'b1;
            sgr.colour  = pal(4'(p0 - 14'd82));
        end
        else if (p0 inside {[14'd100:14'd107]}) begin
            sgr.set_paper = 1'b1;
            sgr.colour    = pal(4'(p0 - 14'd92));
        end
        else if (p0 == 14'd38 || p0 == 14'd48) begin
            if (p1 == 14'd5) begin
                if (p2 <= 14'd255) begin
                    sgr.set_ink   = (p0 == 14'd38);
                    sgr.set_paper = (p0 == 14'd48);
                    sgr.colour    = c256(p2[7:0]);
                end
            end
            else if (p1 == 14'd2) begin
                sgr.set_ink   = (p0 == 14'd38);
                sgr.set_paper = (p0 == 14'd48);
                sgr.colour    = {1'b0, sat5(p4), sat5(p3), sat5(p2)};
            end
        end
    end

endmodule

// ===== rtl/ansi_terminal_escape_engine.sv =====
// ANSI terminal escape engine: parses received bytes and issues framebuffer
// commands (draw, scroll, clear, font row write, cursor update).
// Depends on ate_pkg and ate_sgr.
//
// Usage:
//   Input channel in_valid/in_ready/rx_byte takes one byte per word.
//   Output channel out_valid/out_ready carries one command word per
//   transfer; each byte gives zero, one or two words, and the final word of
//   a byte has last set.
//   Configuration channel cfg_valid/cfg_ready/cfg_index/cfg_data writes the
//   reset ink, reset paper and wrap enable; cfg_ready is always high.
//   A byte is decoded in the cycle it is accepted and its words sit in a
//   four-entry result queue from the next cycle. A byte is accepted every
//   cycle while the queue has at least two free entries; sustained rate is
//   one byte per cycle for bytes that give one word while the receiver
//   takes every word; bytes that give two words are limited by the single
//   output port of the queue.
//   When the receiver stalls, the queue fills and in_ready drops; nothing
//   is lost. Reset homes the cursor, shows it, clears the parser and loads
//   the default colours and registers.
module ansi_terminal_escape_engine #(
    parameter int TEXT_COLS   = ate_pkg::TEXT_COLS_DEF,
    parameter int TEXT_ROWS   = ate_pkg::TEXT_ROWS_DEF,
    parameter int PARAM_SLOTS = ate_pkg::PARAM_SLOTS_DEF,
    parameter int COL_W       = $clog2(TEXT_COLS),
    parameter int ROW_W       = $clog2(TEXT_ROWS)
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    input  logic [7:0]       rx_byte,
    input  logic             cfg_valid,
    output logic             cfg_ready,
    input  logic [1:0]       cfg_index,
    input  logic [15:0]      cfg_data,
    output logic             out_valid,
    input  logic             out_ready,
    output logic [2:0]       op,
    output logic [COL_W-1:0] col,
    output logic [ROW_W-1:0] row,
    output logic [7:0]       glyph,
    output logic [2:0]       font_row,
    output logic [7:0]       font_data,
    output logic [15:0]      fg_pixel,
    output logic [15:0]      bg_pixel,
    output logic [5:0]       scroll_count,
    output logic [2:0]       clear_mode,
    output logic             cursor_on,
    output logic             last
);
    import ate_pkg::*;

    localparam int PI_W   = $clog2(PARAM_SLOTS + 1);
    localparam int PIDX_W = $clog2(PARAM_SLOTS);
    localparam logic [COL_W-1:0] COL_LAST = COL_W'(TEXT_COLS - 1);
    localparam logic [ROW_W-1:0] ROW_LAST = ROW_W'(TEXT_ROWS - 1);

    logic [15:0]      fg_cfg_reg;
    logic [15:0]      bg_cfg_reg;
    logic             wrap_reg;
    phase_t           phase_reg, phase_next;
    logic [13:0]      params_reg [PARAM_SLOTS];
    logic [13:0]      params_next [PARAM_SLOTS];
    logic [PI_W-1:0]  pidx_reg, pidx_next;
    logic             priv_reg, priv_next;
    logic [COL_W-1:0] col_reg, col_next;
    logic [ROW_W-1:0] row_reg, row_next;
    logic [COL_W-1:0] scol_reg, scol_next;
    logic [ROW_W-1:0] srow_reg, srow_next;
    logic [15:0]      ink_reg, ink_next;
    logic [15:0]      paper_reg, paper_next;
    logic             rev_reg, rev_next;
    logic             shown_reg, shown_next;
    logic [3:0]       left_reg, left_next;
    logic [6:0]       target_reg, target_next;

    ate_res_t         fifo_reg [4];
    logic [1:0]       wr_reg;
    logic [1:0]       rd_reg;
    logic [2:0]       cnt_reg;

    logic [13:0]      pv [5];
    ate_sgr_t         sgr;
    logic             take;
    logic             pop;
    logic [1:0]       nres;
    ate_res_t         r0;
    ate_res_t         r1;
    logic             is_final;

    assign cfg_ready = 1'b1;
    assign in_ready  = (cnt_reg <= 3'd2);
    assign take      = in_valid && in_ready;
    assign out_valid = (cnt_reg != 3'd0);
    assign pop       = out_valid && out_ready;
    assign is_final  = (rx_byte >= CH_FIN_LO) && (rx_byte <= CH_FIN_HI);

    always_comb
    begin
        for (int i = 0; i < 5; i++) begin
            pv[i] = 14'd0;
        end
        for (int i = 0; i < PARAM_SLOTS && i < 5; i++) begin
            pv[i] = params_reg[i];
        end
    end

    ate_sgr u_sgr (
        .p0  (pv[0]),
        .p1  (pv[1]),
        .p2  (pv[2]),
        .p3  (pv[3]),
        .p4  (pv[4]),
        .sgr (sgr)
    );

    function automatic ate_res_t mk(
        input op_t              o,
        input logic [COL_W-1:0] c,
        input logic [ROW_W-1:0] r,
        input logic [7:0]       g,
        input logic [2:0]       fr,
        input logic [7:0]       fd,
        input logic [5:0]       n,
        input logic [2:0]       m,
        input logic             con
    );
        ate_res_t res;
        logic     plain;
        plain         = (o == OP_SCROLL) || (o == OP_CLEAR);
        res.op        = o;
        res.col       = 7'(c);
        res.row       = 6'(r);
        res.glyph     = g;
        res.font_row  = fr;
        res.font_data = fd;
        res.fg        = (plain || !rev_reg) ? ink_reg : paper_reg;
        res.bg        = (plain || !rev_reg) ? paper_reg : ink_reg;
        res.cnt       = n;
        res.mode      = m;
        res.con       = con;
        res.last      = 1'b0;
        return res;
    endfunction

    always_comb
    begin
        phase_next = phase_reg;
        case (phase_reg)
            PH_READY:
            begin
                if (left_reg == 4'd0 && rx_byte == CH_ESC) begin
                    phase_next = PH_ESC;
                end
            end
            PH_ESC:
            begin
                phase_next = (rx_byte == CH_LBRACK) ? PH_CSI : PH_READY;
            end
            PH_CSI:
            begin
                if (is_final) begin
                    phase_next = PH_READY;
                end
            end
            default:
            begin
                phase_next = PH_READY;
            end
        endcase
    end

    always_comb
    begin
        logic [13:0]      p0;
        logic [13:0]      n;
        logic [13:0]      h;
        logic [17:0]      v;
        logic [14:0]      sum;
        logic [PIDX_W-1:0] pi;
        logic [COL_W-1:0] cc;
        logic [ROW_W-1:0] rr;
        p0  = pv[0];
        n   = (p0 == 14'd0) ? 14'd1 : p0;
        h   = 14'd0;
        v   = 18'd0;
        sum = 15'd0;
        pi  = pidx_reg[PIDX_W-1:0];
        cc  = col_reg;
        rr  = row_reg;
        for (int i = 0; i < PARAM_SLOTS; i++) begin
            params_next[i] = params_reg[i];
        end
        pidx_next   = pidx_reg;
        priv_next   = priv_reg;
        col_next    = col_reg;
        row_next    = row_reg;
        scol_next   = scol_reg;
        srow_next   = srow_reg;
        ink_next    = ink_reg;
        paper_next  = paper_reg;
        rev_next    = rev_reg;
        shown_next  = shown_reg;
        left_next   = left_reg;
        target_next = target_reg;
        nres        = 2'd0;
        r0          = '0;
        r1          = '0;

        case (phase_reg)
            PH_ESC:
            begin
                for (int i = 0; i < PARAM_SLOTS; i++) begin
                    params_next[i] = 14'd0;
                end
                pidx_next = '0;
                if (rx_byte != CH_LBRACK) begin
                    priv_next = 1'b0;
                end
            end
            PH_CSI:
            begin
                if (rx_byte >= CH_ZERO && rx_byte <= CH_NINE) begin
                    if (pidx_reg < PI_W'(PARAM_SLOTS)) begin
                        v = 18'(params_reg[pi]) * 18'd10 + 18'(rx_byte - CH_ZERO);
                        params_next[pi] = (v > 18'(PARAM_MAX)) ? PARAM_MAX : v[13:0];
                    end
                end
                else if (rx_byte == CH_SEMI) begin
                    if (pidx_reg < PI_W'(PARAM_SLOTS)) begin
                        pidx_next = pidx_reg + 1'b1;
                    end
                end
                else if (rx_byte == CH_QUEST) begin
                    priv_next = 1'b1;
                end
                else if (is_final) begin
                    case (rx_byte)
                        CH_H:
                        begin
                            h = (p0 == 14'd0) ? 14'd0 : p0 - 14'd1;
                            rr = (h >= 14'(TEXT_ROWS)) ? ROW_LAST : h[ROW_W-1:0];
                            h = (pv[1] == 14'd0) ? 14'd0 : pv[1] - 14'd1;
                            cc = (h >= 14'(TEXT_COLS)) ? COL_LAST : h[COL_W-1:0];
                            nres = 2'd1;
                        end
                        CH_A:
                        begin
                            rr = (n >= 14'(row_reg)) ? '0 : row_reg - n[ROW_W-1:0];
                            nres = 2'd1;
                        end
                        CH_B:
                        begin
                            sum = 15'(row_reg) + 15'(n);
                            rr = (sum >= 15'(TEXT_ROWS)) ? ROW_LAST : sum[ROW_W-1:0];
                            nres = 2'd1;
                        end
                        CH_C:
                        begin
                            sum = 15'(col_reg) + 15'(n);
                            cc = (sum >= 15'(TEXT_COLS)) ? COL_LAST : sum[COL_W-1:0];
                            nres = 2'd1;
                        end
                        CH_D:
                        begin
                            cc = (n >= 14'(col_reg)) ? '0 : col_reg - n[COL_W-1:0];
                            nres = 2'd1;
                        end
                        CH_LH, CH_LL:
                        begin
                            if (priv_reg && p0 == 14'd25) begin
                                shown_next = (rx_byte == CH_LH);
                                nres = 2'd1;
                            end
                        end
                        CH_LM:
                        begin
                            if (sgr.ink_reset) begin
                                ink_next = fg_cfg_reg;
                            end
                            if (sgr.set_ink) begin
                                ink_next = sgr.colour;
                            end
                            if (sgr.set_paper) begin
                                paper_next = sgr.colour;
                            end
                            if (sgr.rev_on) begin
                                rev_next = 1'b1;
                            end
                            if (sgr.rev_off) begin
                                rev_next = 1'b0;
                            end
                        end
                        CH_LS:
                        begin
                            scol_next = col_reg;
                            srow_next = row_reg;
                        end
                        CH_LU:
                        begin
                            cc = scol_reg;
                            rr = srow_reg;
                            nres = 2'd1;
                        end
                        CH_J:
                        begin
                            if (p0 <= 14'd1) begin
                                r0 = mk(OP_CLEAR, col_reg, row_reg, 8'd0, 3'd0, 8'd0,
                                        6'd0, 3'(p0), shown_reg);
                                nres = 2'd1;
                            end
                            else if (p0 <= 14'd3) begin
                                r0 = mk(OP_CLEAR, col_reg, row_reg, 8'd0, 3'd0, 8'd0,
                                        6'd0, CLR_SCR, shown_reg);
                                r1 = mk(OP_CURSOR, '0, '0, 8'd0, 3'd0, 8'd0,
                                        6'd0, 3'd0, shown_reg);
                                cc = '0;
                                rr = '0;
                                nres = 2'd2;
                            end
                        end
                        CH_K:
                        begin
                            if (p0 <= 14'd2) begin
                                r0 = mk(OP_CLEAR, col_reg, row_reg, 8'd0, 3'd0, 8'd0,
                                        6'd0, CLR_LINE_FROM + 3'(p0), shown_reg);
                                nres = 2'd1;
                            end
                        end
                        CH_S:
                        begin
                            r0 = mk(OP_SCROLL, col_reg, row_reg, 8'd0, 3'd0, 8'd0,
                                    (n > 14'd32) ? 6'd32 : 6'(n), 3'd0, shown_reg);
                            nres = 2'd1;
                        end
                        CH_U:
                        begin
                            if (priv_reg) begin
                                left_next   = 4'd8;
                                target_next = p0[6:0];
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                    if (rx_byte == CH_H || rx_byte == CH_A || rx_byte == CH_B ||
                        rx_byte == CH_C || rx_byte == CH_D || rx_byte == CH_LU ||
                        rx_byte == CH_LH || rx_byte == CH_LL) begin
                        r0 = mk(OP_CURSOR, cc, rr, 8'd0, 3'd0, 8'd0, 6'd0, 3'd0,
                                shown_next);
                    end
                    col_next = cc;
                    row_next = rr;
                    for (int i = 0; i < PARAM_SLOTS; i++) begin
                        params_next[i] = 14'd0;
                    end
                    pidx_next = '0;
                    priv_next = 1'b0;
                end
            end
            default:
            begin
                if (left_reg != 4'd0) begin
                    r0 = mk(OP_FONT, col_reg, row_reg, 8'd96 + 8'(target_reg),
                            3'(4'd8 - left_reg), rx_byte, 6'd0, 3'd0, shown_reg);
                    left_next = left_reg - 4'd1;
                    nres = 2'd1;
                end
                else if (rx_byte >= CH_SPACE) begin
                    r0 = mk(OP_DRAW, col_reg, row_reg, rx_byte - CH_SPACE, 3'd0, 8'd0,
                            6'd0, 3'd0, shown_reg);
                    nres = 2'd2;
                    if (!wrap_reg) begin
                        if (col_reg < COL_LAST) begin
                            cc = col_reg + 1'b1;
                        end
                        r1 = mk(OP_CURSOR, cc, rr, 8'd0, 3'd0, 8'd0, 6'd0, 3'd0,
                                shown_reg);
                    end
                    else if (col_reg >= COL_LAST) begin
                        cc = '0;
                        if (row_reg >= ROW_LAST) begin
                            r1 = mk(OP_SCROLL, cc, rr, 8'd0, 3'd0, 8'd0, 6'd1, 3'd0,
                                    shown_reg);
                        end
                        else begin
                            rr = row_reg + 1'b1;
                            r1 = mk(OP_CURSOR, cc, rr, 8'd0, 3'd0, 8'd0, 6'd0, 3'd0,
                                    shown_reg);
                        end
                    end
                    else begin
                        cc = col_reg + 1'b1;
                        r1 = mk(OP_CURSOR, cc, rr, 8'd0, 3'd0, 8'd0, 6'd0, 3'd0,
                                shown_reg);
                    end
                end
                else begin
                    case (rx_byte)
                        CH_BS:
                        begin
                            if (col_reg != '0) begin
                                cc = col_reg - 1'b1;
                            end
                            r0 = mk(OP_CURSOR, cc, rr, 8'd0, 3'd0, 8'd0, 6'd0, 3'd0,
                                    shown_reg);
                            nres = 2'd1;
                        end
                        CH_LF:
                        begin
                            if (row_reg >= ROW_LAST) begin
                                r0 = mk(OP_SCROLL, cc, rr, 8'd0, 3'd0, 8'd0, 6'd1,
                                        3'd0, shown_reg);
                            end
                            else begin
                                rr = row_reg + 1'b1;
                                r0 = mk(OP_CURSOR, cc, rr, 8'd0, 3'd0, 8'd0, 6'd0,
                                        3'd0, shown_reg);
                            end
                            nres = 2'd1;
                        end
                        CH_CR:
                        begin
                            cc = '0;
                            r0 = mk(OP_CURSOR, cc, rr, 8'd0, 3'd0, 8'd0, 6'd0, 3'd0,
                                    shown_reg);
                            nres = 2'd1;
                        end
                        CH_FF:
                        begin
                            r0 = mk(OP_CLEAR, col_reg, row_reg, 8'd0, 3'd0, 8'd0,
                                    6'd0, CLR_SCR, shown_reg);
                            cc = '0;
                            rr = '0;
                            r1 = mk(OP_CURSOR, cc, rr, 8'd0, 3'd0, 8'd0, 6'd0, 3'd0,
                                    shown_reg);
                            nres = 2'd2;
                        end
                        default:
                        begin
                        end
                    endcase
                end
                col_next = cc;
                row_next = rr;
            end
        endcase

        if (nres == 2'd1) begin
            r0.last = 1'b1;
        end
        else begin
            r1.last = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            fg_cfg_reg <= FG_RESET;
            bg_cfg_reg <= BG_RESET;
            wrap_reg   <= 1'b1;
        end
        else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                CFG_FG:   fg_cfg_reg <= cfg_data;
                CFG_BG:   bg_cfg_reg <= cfg_data;
                CFG_WRAP: wrap_reg   <= cfg_data[0];
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            phase_reg  <= PH_READY;
            for (int i = 0; i < PARAM_SLOTS; i++) begin
                params_reg[i] <= 14'd0;
            end
            pidx_reg   <= '0;
            priv_reg   <= 1'b0;
            col_reg    <= '0;
            row_reg    <= '0;
            scol_reg   <= '0;
            srow_reg   <= '0;
            ink_reg    <= FG_RESET;
            paper_reg  <= BG_RESET;
            rev_reg    <= 1'b0;
            shown_reg  <= 1'b1;
            left_reg   <= 4'd0;
            target_reg <= 7'd0;
        end
        else if (take) begin
            phase_reg  <= phase_next;
            for (int i = 0; i < PARAM_SLOTS; i++) begin
                params_reg[i] <= params_next[i];
            end
            pidx_reg   <= pidx_next;
            priv_reg   <= priv_next;
            col_reg    <= col_next;
            row_reg    <= row_next;
            scol_reg   <= scol_next;
            srow_reg   <= srow_next;
            ink_reg    <= ink_next;
            paper_reg  <= paper_next;
            rev_reg    <= rev_next;
            shown_reg  <= shown_next;
            left_reg   <= left_next;
            target_reg <= target_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take && nres != 2'd0) begin
            fifo_reg[wr_reg] <= r0;
            if (nres == 2'd2) begin
                fifo_reg[wr_reg + 2'd1] <= r1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            wr_reg  <= 2'd0;
            rd_reg  <= 2'd0;
            cnt_reg <= 3'd0;
        end
        else begin
            if (take) begin
                wr_reg <= wr_reg + nres;
            end
            if (pop) begin
                rd_reg <= rd_reg + 2'd1;
            end
            cnt_reg <= cnt_reg + (take ? 3'(nres) : 3'd0) - (pop ? 3'd1 : 3'd0);
        end
    end

    assign op           = fifo_reg[rd_reg].op;
    assign col          = fifo_reg[rd_reg].col[COL_W-1:0];
    assign row          = fifo_reg[rd_reg].row[ROW_W-1:0];
    assign glyph        = fifo_reg[rd_reg].glyph;
    assign font_row     = fifo_reg[rd_reg].font_row;
    assign font_data    = fifo_reg[rd_reg].font_data;
    assign fg_pixel     = fifo_reg[rd_reg].fg;
    assign bg_pixel     = fifo_reg[rd_reg].bg;
    assign scroll_count = fifo_reg[rd_reg].cnt;
    assign clear_mode   = fifo_reg[rd_reg].mode;
    assign cursor_on    = fifo_reg[rd_reg].con;
    assign last         = fifo_reg[rd_reg].last;

endmodule

// ===== rtl/ate_checker.sv =====
// Port-level checks of the ANSI terminal escape engine, bound to the top.
// Depends on ate_pkg.
module ate_checker #(
    parameter int COL_W = 6,
    parameter int ROW_W = 5
) (
    input logic             clk,
    input logic             rst_n,
    input logic             out_valid,
    input logic             out_ready,
    input logic [2:0]       op,
    input logic [COL_W-1:0] col,
    input logic [ROW_W-1:0] row,
    input logic [5:0]       scroll_count,
    input logic [2:0]       clear_mode,
    input logic             last
);
    import ate_pkg::*;

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(op) && $stable(col) && $stable(row))
        else $error("output word dropped while stalled");

    a_draw_follow: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && op == OP_DRAW |-> !last)
        else $error("draw word marked last");

    a_scroll_cnt: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && op == OP_SCROLL |-> scroll_count != 6'd0 && scroll_count <= 6'd32)
        else $error("scroll count out of range");

    a_clear_mode: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && op == OP_CLEAR |-> clear_mode <= 3'd5)
        else $error("bad clear word");

endmodule

bind ansi_terminal_escape_engine ate_checker #(
    .COL_W (COL_W),
    .ROW_W (ROW_W)
) u_ate_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .op           (op),
    .col          (col),
    .row          (row),
    .scroll_count (scroll_count),
    .clear_mode   (clear_mode),
    .last         (last)
);

// ===== tb/ansi_terminal_escape_engine_tb.sv =====
// Self-checking bench for the ANSI terminal escape engine: byte streams in,
// command words out, checked against a built-in decoder model.
// Depends on ate_pkg and the ansi_terminal_escape_engine top level.
module ansi_terminal_escape_engine_tb;
    import ate_pkg::*;

    typedef struct packed {
        op_t         op;
        logic [5:0]  col;
        logic [4:0]  row;
        logic [7:0]  glyph;
        logic [2:0]  font_row;
        logic [7:0]  font_data;
        logic [15:0] fg;
        logic [15:0] bg;
        logic [5:0]  cnt;
        logic [2:0]  mode;
        logic        con;
        logic        last;
    } cmd_word_t;

    localparam int COLS = TEXT_COLS_DEF;
    localparam int ROWS = TEXT_ROWS_DEF;
    localparam int SLOTS = PARAM_SLOTS_DEF;
    localparam int BASE_RGB [48] = '{
        0, 0, 0, 170, 0, 0, 0, 170, 0, 170, 85, 0,
        0, 0, 170, 170, 0, 170, 0, 170, 170, 170, 170, 170,
        85, 85, 85, 255, 85, 85, 85, 255, 85, 255, 255, 85,
        0, 0, 255, 255, 85, 255, 85, 255, 255, 255, 255, 255};

    logic clk, rst_n;
    logic in_valid, in_ready;
    logic [7:0] rx_byte;
    logic cfg_valid, cfg_ready;
    logic [1:0] cfg_index;
    logic [15:0] cfg_data;
    logic out_valid, out_ready;
    logic [2:0] op;
    logic [5:0] col;
    logic [4:0] row;
    logic [7:0] glyph, font_data;
    logic [2:0] font_row, clear_mode;
    logic [15:0] fg_pixel, bg_pixel;
    logic [5:0] scroll_count;
    logic cursor_on, last;

    ansi_terminal_escape_engine dut (.*);

    // decoder model state
    int unsigned reg_fg = FG_RESET, reg_bg = BG_RESET, reg_wrap = 1;
    phase_t phase = PH_READY;
    int unsigned prm [SLOTS];
    int unsigned pidx = 0, priv = 0;
    int unsigned ccol = 0, crow = 0, scol = 0, srow = 0;
    int unsigned ink = FG_RESET, paper = BG_RESET, rev = 0, shown = 1;
    int unsigned gleft = 0, gtgt = 0;

    cmd_word_t cmd_expect [$];
    cmd_word_t step_words [$];
    byte unsigned byte_pend [$];
    int unsigned bytes_sent = 0, bytes_taken = 0, words_seen = 0, cfg_writes = 0;
    int unsigned mismatches = 0;
    int in_wait = 0, out_stall = 0;
    int unsigned words_done = 0;

    function automatic int unsigned sat8(int unsigned v);
        return v > 255 ? 255 : v;
    endfunction

    function automatic int unsigned rgb_pixel(int unsigned r, int unsigned g, int unsigned b);
        return (sat8(r) >> 3) | ((sat8(g) >> 3) << 5) | ((sat8(b) >> 3) << 10);
    endfunction

    function automatic int unsigned base_pixel(int unsigned i);
        return rgb_pixel(BASE_RGB[i*3], BASE_RGB[i*3+1], BASE_RGB[i*3+2]);
    endfunction

    task automatic add_word(op_t o, int unsigned c, int unsigned r, int unsigned g,
                            int unsigned fr, int unsigned fd, int unsigned n,
                            int unsigned md);
        cmd_word_t w;
        bit plain;
        if (step_words.size() >= 2) return;
        plain = (o == OP_SCROLL) || (o == OP_CLEAR);
        w.op = o; w.col = 6'(c); w.row = 5'(r); w.glyph = 8'(g);
        w.font_row = 3'(fr); w.font_data = 8'(fd); w.cnt = 6'(n); w.mode = 3'(md);
        w.fg = 16'((plain || !rev) ? ink : paper);
        w.bg = 16'((plain || !rev) ? paper : ink);
        w.con = shown[0]; w.last = 1'b0;
        step_words.push_back(w);
    endtask

    task automatic cursor_word();
        add_word(OP_CURSOR, ccol, crow, 0, 0, 0, 0, 0);
    endtask

    task automatic close_seq();
        foreach (prm[i]) prm[i] = 0;
        pidx = 0; priv = 0; phase = PH_READY;
    endtask

    task automatic apply_sgr();
        int unsigned p0, p1, n, cc, gg, px;
        bit ok;
        p0 = prm[0]; p1 = prm[1]; ok = 0; px = 0;
        if (p0 == 0) begin rev = 0; ink = reg_fg; end
        else if (p0 == 7) rev = 1;
        else if (p0 >= 30 && p0 <= 37) ink = base_pixel(p0 - 30);
        else if (p0 >= 40 && p0 <= 47) paper = base_pixel(p0 - 40);
        else if (p0 >= 90 && p0 <= 97) ink = base_pixel(p0 - 82);
        else if (p0 >= 100 && p0 <= 107) paper = base_pixel(p0 - 92);
        else if (p0 == 38 || p0 == 48) begin
            if (p1 == 5) begin
                n = prm[2];
                if (n <= 15) begin px = base_pixel(n); ok = 1; end
                else if (n <= 231) begin
                    cc = n - 16;
                    px = rgb_pixel((cc / 36) * 42, ((cc / 6) % 6) * 42, (cc % 6) * 42);
                    ok = 1;
                end
                else if (n <= 255) begin
                    gg = ((n - 232) * 106) / 10;
                    px = rgb_pixel(gg, gg, gg);
                    ok = 1;
                end
            end
            else if (p1 == 2) begin
                px = rgb_pixel(prm[2], prm[3], prm[4]);
                ok = 1;
            end
            if (ok) begin
                if (p0 == 38) ink = px;
                else paper = px;
            end
        end
    endtask

    task automatic run_final(byte unsigned f);
        int unsigned p0, n;
        p0 = prm[0];
        n = (p0 == 0) ? 1 : p0;
        case (f)
            CH_H: begin
                crow = (p0 == 0) ? 0 : ((p0 - 1 >= ROWS) ? ROWS - 1 : p0 - 1);
                ccol = (prm[1] == 0) ? 0 : ((prm[1] - 1 >= COLS) ? COLS - 1 : prm[1] - 1);
                cursor_word();
            end
            CH_A: begin crow = (n >= crow) ? 0 : crow - n; cursor_word(); end
            CH_B: begin crow = (crow + n >= ROWS) ? ROWS - 1 : crow + n; cursor_word(); end
            CH_C: begin ccol = (ccol + n >= COLS) ? COLS - 1 : ccol + n; cursor_word(); end
            CH_D: begin ccol = (n >= ccol) ? 0 : ccol - n; cursor_word(); end
            CH_LH, CH_LL: begin
                if (priv && p0 == 25) begin
                    shown = (f == CH_LH);
                    cursor_word();
                end
            end
            CH_LM: apply_sgr();
            CH_LS: begin scol = ccol; srow = crow; end
            CH_LU: begin ccol = scol; crow = srow; cursor_word(); end
            CH_J: begin
                if (p0 <= 1) add_word(OP_CLEAR, ccol, crow, 0, 0, 0, 0, p0);
                else if (p0 <= 3) begin
                    add_word(OP_CLEAR, ccol, crow, 0, 0, 0, 0, CLR_SCR);
                    ccol = 0; crow = 0;
                    cursor_word();
                end
            end
            CH_K: if (p0 <= 2) add_word(OP_CLEAR, ccol, crow, 0, 0, 0, 0, CLR_LINE_FROM + p0);
            CH_S: add_word(OP_SCROLL, ccol, crow, 0, 0, 0, n > 32 ? 32 : n, 0);
            CH_U: if (priv) begin gleft = 8; gtgt = p0 % 128; end
            default: ;
        endcase
        close_seq();
    endtask

    task automatic decode_byte(byte unsigned b);
        int unsigned v;
        step_words.delete();
        if (phase == PH_ESC) begin
            if (b == CH_LBRACK) begin
                foreach (prm[i]) prm[i] = 0;
                pidx = 0; phase = PH_CSI;
            end
            else close_seq();
        end
        else if (phase == PH_CSI) begin
            if (b >= CH_ZERO && b <= CH_NINE) begin
                if (pidx < SLOTS) begin
                    v = prm[pidx] * 10 + (b - CH_ZERO);
                    prm[pidx] = v > PARAM_MAX ? PARAM_MAX : v;
                end
            end
            else if (b == CH_SEMI) begin
                if (pidx < SLOTS) pidx++;
            end
            else if (b == CH_QUEST) priv = 1;
            else if (b >= CH_FIN_LO && b <= CH_FIN_HI) run_final(b);
        end
        else if (gleft != 0) begin
            add_word(OP_FONT, ccol, crow, 96 + gtgt, 8 - gleft, b, 0, 0);
            gleft--;
        end
        else if (b >= CH_SPACE) begin
            add_word(OP_DRAW, ccol, crow, b - 32, 0, 0, 0, 0);
            if (!reg_wrap) begin
                if (ccol + 1 < COLS) ccol++;
                cursor_word();
            end
            else begin
                ccol++;
                if (ccol >= COLS) begin
                    ccol = 0;
                    if (crow >= ROWS - 1) add_word(OP_SCROLL, ccol, crow, 0, 0, 0, 1, 0);
                    else begin crow++; cursor_word(); end
                end
                else cursor_word();
            end
        end
        else begin
            case (b)
                CH_ESC: phase = PH_ESC;
                CH_BS: begin if (ccol > 0) ccol--; cursor_word(); end
                CH_LF: begin
                    if (crow >= ROWS - 1) add_word(OP_SCROLL, ccol, crow, 0, 0, 0, 1, 0);
                    else begin crow++; cursor_word(); end
                end
                CH_CR: begin ccol = 0; cursor_word(); end
                CH_FF: begin
                    add_word(OP_CLEAR, ccol, crow, 0, 0, 0, 0, CLR_SCR);
                    ccol = 0; crow = 0;
                    cursor_word();
                end
                default: ;
            endcase
        end
        if (step_words.size() > 0) step_words[step_words.size()-1].last = 1'b1;
        foreach (step_words[i]) cmd_expect.push_back(step_words[i]);
    endtask

    initial begin
        clk = 0;
        forever #6 clk = ~clk;
    end

    initial begin
        #(12 * 500000);
        $display("FAILURE");
        $finish;
    end

    // input driver
    always @(negedge clk) begin
        bit taken;
        taken = in_valid && (bytes_taken == bytes_sent);
        if (taken) in_wait = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 11);
        if (!in_valid || taken) begin
            if (in_wait == 0 && byte_pend.size() > 0 && rst_n) begin
                rx_byte <= byte_pend.pop_front();
                in_valid <= 1;
                bytes_sent++;
                in_wait = $urandom_range(0, 11);
            end
            else begin
                in_valid <= 0;
                if (in_wait > 0) in_wait--;
            end
        end
    end

    // output ready driver
    always @(negedge clk) begin
        if (words_done != words_seen) begin
            words_done = words_seen;
            out_stall = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 11);
        end
        if (out_stall > 0) begin
            out_ready <= 0;
            out_stall--;
        end
        else out_ready <= 1;
    end

    // monitor and model update
    always @(posedge clk) begin
        cmd_word_t got, want;
        if (rst_n) begin
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    CFG_FG:   reg_fg = cfg_data;
                    CFG_BG:   reg_bg = cfg_data;
                    CFG_WRAP: reg_wrap = cfg_data[0];
                    default: ;
                endcase
                cfg_writes++;
            end
            if (in_valid && in_ready) begin
                decode_byte(rx_byte);
                bytes_taken++;
            end
            if (out_valid && out_ready) begin
                words_seen++;
                got = '{op_t'(op), col, row, glyph, font_row, font_data, fg_pixel,
                        bg_pixel, scroll_count, clear_mode, cursor_on, last};
                if (cmd_expect.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10) $display("unexpected word %h", got);
                end
                else begin
                    want = cmd_expect.pop_front();
                    if (got.op !== want.op || got.col !== want.col || got.row !== want.row ||
                        got.glyph !== want.glyph || got.font_row !== want.font_row ||
                        got.font_data !== want.font_data || got.fg !== want.fg ||
                        got.bg !== want.bg || got.cnt !== want.cnt ||
                        got.mode !== want.mode || got.con !== want.con ||
                        got.last !== want.last) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("word %0d mismatch: expected %h got %h",
                                     words_seen, want, got);
                    end
                end
            end
        end
    end

    task automatic push_str(string s);
        foreach (s[i]) byte_pend.push_back(s[i]);
    endtask

    task automatic push_csi(string body);
        byte_pend.push_back(CH_ESC);
        push_str({"[", body});
    endtask

    task automatic write_reg(logic [1:0] idx, logic [15:0] val);
        @(negedge clk);
        cfg_valid <= 1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        @(negedge clk);
        cfg_valid <= 0;
    endtask

    task automatic drain();
        while (byte_pend.size() > 0 || in_valid || cmd_expect.size() > 0) @(posedge clk);
        repeat (6) @(posedge clk);
    endtask

    task automatic push_param();
        case ($urandom_range(0, 5))
            0: ;
            1: push_str($sformatf("%0d", $urandom_range(0, 9)));
            2: push_str($sformatf("%0d", $urandom_range(0, 120)));
            3: push_str($sformatf("%0d", $urandom_range(0, 300)));
            4: push_str($sformatf("%0d", $urandom_range(0, 99999)));
            default: push_str($sformatf("%0d", $urandom_range(20, 40)));
        endcase
    endtask

    task automatic random_chunk();
        string fins;
        int k, n;
        fins = "HABCDsuJKSmhlU";
        case ($urandom_range(0, 13))
            0, 1: begin
                n = $urandom_range(1, 12);
                repeat (n) byte_pend.push_back(8'($urandom_range(32, 255)));
            end
            2: begin
                k = $urandom_range(0, 3);
                byte_pend.push_back(k == 0 ? CH_BS : k == 1 ? CH_LF : k == 2 ? CH_CR : CH_FF);
            end
            3: byte_pend.push_back(8'($urandom_range(0, 255)));
            4: begin
                push_csi($sformatf("%0d;%0dH", $urandom_range(ROWS - 1, ROWS + 2),
                                   $urandom_range(COLS - 4, COLS + 1)));
                n = $urandom_range(2, 8);
                repeat (n) byte_pend.push_back(8'($urandom_range(32, 126)));
            end
            5: push_csi($sformatf("%0d;%0d;%0dm", $urandom_range(0, 1) ? 38 : 48,
                                  $urandom_range(0, 1) ? 5 : 2, $urandom_range(0, 300)));
            6: push_csi($sformatf("%0d;2;%0d;%0d;%0dm", $urandom_range(0, 1) ? 38 : 48,
                                  $urandom_range(0, 400), $urandom_range(0, 400),
                                  $urandom_range(0, 400)));
            7: push_csi($sformatf("%0dm", $urandom_range(0, 110)));
            8: begin
                push_csi($sformatf("?%0dU", $urandom_range(0, 300)));
                repeat (8) byte_pend.push_back(8'($urandom_range(0, 255)));
            end
            9: push_csi($sformatf("?25%s", $urandom_range(0, 1) ? "h" : "l"));
            10: begin
                byte_pend.push_back(CH_ESC);
                byte_pend.push_back(8'($urandom_range(0, 255)));
            end
            default: begin
                byte_pend.push_back(CH_ESC);
                byte_pend.push_back(CH_LBRACK);
                if ($urandom_range(0, 5) == 0) byte_pend.push_back(CH_QUEST);
                n = $urandom_range(0, 6);
                push_param();
                repeat (n) begin
                    byte_pend.push_back(CH_SEMI);
                    push_param();
                end
                if ($urandom_range(0, 6) == 0) byte_pend.push_back(8'($urandom_range(0, 31)));
                if ($urandom_range(0, 4) == 0) byte_pend.push_back(8'($urandom_range(64, 125)));
                else byte_pend.push_back(fins[$urandom_range(0, fins.len() - 1)]);
            end
        endcase
    endtask

    initial begin
        int unsigned target;
        foreach (prm[i]) prm[i] = 0;
        rst_n = 0;
        in_valid = 0;
        rx_byte = 0;
        cfg_valid = 0;
        cfg_index = CFG_FG;
        cfg_data = 0;
        out_ready = 0;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1;

        // directed: extremes, controls, every final, glyph upload
        byte_pend.push_back(8'h20); byte_pend.push_back(8'hFF); byte_pend.push_back(8'h7F);
        byte_pend.push_back(8'h00); byte_pend.push_back(CH_BS); byte_pend.push_back(CH_LF);
        byte_pend.push_back(CH_CR); byte_pend.push_back(CH_FF);
        byte_pend.push_back(CH_ESC); byte_pend.push_back("x");
        push_csi("99;99H"); push_str("AB");
        push_csi("0;0H"); push_csi("A"); push_csi("3B"); push_csi("50C"); push_csi("0D");
        push_csi("s"); push_csi("5;5H"); push_csi("u");
        push_csi("1;2;3;4;5;6;77777J"); push_csi("1J"); push_csi("3J"); push_csi("9J");
        push_csi("K"); push_csi("1K"); push_csi("2K"); push_csi("7K");
        push_csi("0S"); push_csi("99S");
        push_csi("7m"); push_str("r"); push_csi("41m"); push_csi("97m"); push_csi("0m");
        push_csi("?25l"); push_csi("25h"); push_csi("?25h"); push_csi("5U");
        byte_pend.push_back(CH_ESC); byte_pend.push_back(CH_LBRACK);
        byte_pend.push_back(8'h7E); byte_pend.push_back(8'h01); push_str("~Z");
        push_csi("?200U");
        byte_pend.push_back(CH_ESC);
        repeat (7) byte_pend.push_back(8'($urandom_range(0, 255)));
        push_csi("29;40H"); push_str("xy");
        drain();

        for (int ph = 0; ph < 4; ph++) begin
            case (ph)
                0: begin write_reg(CFG_FG, 16'h0000); write_reg(CFG_BG, 16'hFFFF);
                         write_reg(CFG_WRAP, 16'h0000); end
                1: begin write_reg(CFG_FG, 16'hFFFF); write_reg(CFG_BG, 16'h0000);
                         write_reg(CFG_WRAP, 16'h0001); end
                2: begin write_reg(CFG_FG, 16'($urandom_range(0, 65535)));
                         write_reg(CFG_BG, 16'($urandom_range(0, 65535)));
                         write_reg(CFG_WRAP, 16'hFFFE); end
                default: begin write_reg(CFG_FG, 16'($urandom_range(0, 65535)));
                         write_reg(CFG_WRAP, 16'h0001); end
            endcase
            push_csi("0m");
            target = bytes_sent + 185;
            while (bytes_sent + byte_pend.size() < target) begin
                random_chunk();
                while (byte_pend.size() > 16) @(posedge clk);
            end
            drain();
        end

        repeat (10) @(posedge clk);
        $display("run covered %0d bytes, %0d command words, %0d register writes",
                 bytes_taken, words_seen, cfg_writes);
        $display("%0d mismatches, %0d words still expected", mismatches, cmd_expect.size());
        if (mismatches == 0 && cmd_expect.size() == 0) begin
            $display("SUCCESS");
        end
        else begin
            $display("FAILURE");
        end
        $finish;
    end
endmodule
